@@ design/ilsc_pkg.sv @@
// ----------------------------------------------------------------------------
// ilsc_pkg
// shared types and constants of the integer literal scanner
// ----------------------------------------------------------------------------
package ilsc_pkg;

    // scanner modes
    typedef enum logic [3:0] {
        MODE_IDLE  = 4'd0,
        MODE_ZERO  = 4'd1,
        MODE_DEC   = 4'd2,
        MODE_OCT   = 4'd3,
        MODE_HEXX  = 4'd4,
        MODE_HEX   = 4'd5,
        MODE_SKIPD = 4'd6,
        MODE_SKIPH = 4'd7,
        MODE_DOT   = 4'd8,
        MODE_SUF   = 4'd9
    } mode_t;

    // result kinds
    typedef enum logic [2:0] {
        KIND_INT64 = 3'd0,
        KIND_INT16 = 3'd1,
        KIND_INT32 = 3'd2,
        KIND_BYTE  = 3'd3,
        KIND_ERROR = 3'd4,
        KIND_REAL  = 3'd5
    } kind_t;

    // fault codes
    typedef enum logic [2:0] {
        FAULT_NONE       = 3'd0,
        FAULT_BAD_SUFFIX = 3'd1,
        FAULT_TOO_LARGE  = 3'd2,
        FAULT_DECIMAL    = 3'd3,
        FAULT_OCTAL      = 3'd4,
        FAULT_HEX        = 3'd5,
        FAULT_GARBAGE    = 3'd6
    } fault_t;

    // largest values that may take one more digit; decimal also checks carry
    localparam logic [63:0] DEC_LIMIT = 64'h1999_9999_9999_9999;
    localparam logic [63:0] OCT_LIMIT = 64'h1FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] HEX_LIMIT = 64'h0FFF_FFFF_FFFF_FFFF;

    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_1     = 8'h31;
    localparam logic [7:0] CHAR_7     = 8'h37;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;
    localparam logic [7:0] CHAR_APOS  = 8'h27;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_F  = 8'h66;
    localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_F  = 8'h46;
    localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LC_S  = 8'h73;
    localparam logic [7:0] CHAR_UC_S  = 8'h53;
    localparam logic [7:0] CHAR_LC_T  = 8'h74;
    localparam logic [7:0] CHAR_UC_T  = 8'h54;
    localparam logic [7:0] CHAR_LC_X  = 8'h78;
    localparam logic [7:0] CHAR_UC_X  = 8'h58;

endpackage

@@ design/ilsc_byte_if.sv @@
// ----------------------------------------------------------------------------
// ilsc_byte_if
// source byte channel: one byte or an end-of-text mark per beat
// ----------------------------------------------------------------------------
interface ilsc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       is_end;

    modport source (output valid, output ch, output is_end, input ready);
    modport sink   (input valid, input ch, input is_end, output ready);
endinterface

@@ design/ilsc_result_if.sv @@
// ----------------------------------------------------------------------------
// ilsc_result_if
// result channel: one scanned literal per beat
// ----------------------------------------------------------------------------
interface ilsc_result_if;
    import ilsc_pkg::*;

    logic         valid;
    logic         ready;
    kind_t        kind;
    logic [63:0]  number_value;
    fault_t       fault;
    logic [7:0]   token_length;

    modport source (output valid, output kind, output number_value, output fault,
                    output token_length, input ready);
    modport sink   (input valid, input kind, input number_value, input fault,
                    input token_length, output ready);
endinterface

@@ design/integer_literal_scanner_top.sv @@
// ----------------------------------------------------------------------------
// integer_literal_scanner_top
// scans decimal, octal and hex integer literals one byte per beat
// output: a result beat is registered and shown in the cycle after the byte beat that ends it
// throughput: one byte beat per cycle; the scan state updates in a single pass
// a result held back by the sink stalls bytes, one drained that cycle does not
// reset: asynchronous, active low; scanner idle, output register empty
// ----------------------------------------------------------------------------
module integer_literal_scanner_top #(
    parameter int MAX_TOKEN_LENGTH = 255
) (
    input  logic          clk,
    input  logic          rst_n,
    ilsc_byte_if.sink     byte_chan,
    ilsc_result_if.source result_chan
);
    import ilsc_pkg::*;

    // token length saturates at the smaller of the limit and the field width
    localparam int         LEN_CAP_INT = (MAX_TOKEN_LENGTH < 255) ? MAX_TOKEN_LENGTH : 255;
    localparam logic [7:0] LEN_CAP     = 8'(LEN_CAP_INT);

    // scan state
    mode_t       mode_reg, mode_next;
    logic [63:0] acc_reg, acc_next;
    fault_t      pf_reg, pf_next;
    logic [7:0]  sfc_reg, sfc_next;
    logic [1:0]  sfn_reg, sfn_next;
    logic [7:0]  len_reg, len_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    kind_t       kind_reg;
    logic [63:0] value_reg;
    fault_t      fault_reg;
    logic [7:0]  tlen_reg;

    logic        accept;
    logic [7:0]  c;
    logic        at_end;

    // byte classes
    logic        is_dig, is_oct, is_sep, is_alpha, is_alnum, is_garb, is_hex, is_x;
    logic [3:0]  hex_digit;

    // digit accumulation
    logic        dec_ovf;
    logic [63:0] times_ten;
    logic [64:0] dec_sum;

    // finish of an integer literal
    kind_t       fin_kind;
    logic [63:0] fin_value;
    fault_t      fin_fault;

    // result of this beat
    logic        emit;
    kind_t       emit_kind;
    logic [63:0] emit_value;
    fault_t      emit_fault;
    logic        clear;
    logic        bump;

    assign c      = byte_chan.ch;
    assign at_end = byte_chan.is_end;

    // the output register is free, or is being drained this cycle
    assign byte_chan.ready = !out_valid_reg || result_chan.ready;
    assign accept          = byte_chan.valid && byte_chan.ready;

    // ------------------------------------------------------------------------
    // character classes
    // ------------------------------------------------------------------------
    always_comb
    begin
        is_dig   = (c >= CHAR_0) && (c <= CHAR_9);
        is_oct   = (c >= CHAR_0) && (c <= CHAR_7);
        is_sep   = (c == CHAR_UNDER) || (c == CHAR_APOS) || (c == CHAR_QUOTE);
        is_alpha = ((c >= CHAR_LC_A) && (c <= CHAR_LC_Z)) ||
                   ((c >= CHAR_UC_A) && (c <= CHAR_UC_Z));
        is_alnum = is_dig || is_alpha;
        is_garb  = is_alnum || (c == CHAR_UNDER) || c[7];
        is_x     = (c == CHAR_LC_X) || (c == CHAR_UC_X);
        is_hex   = 1'b1;
        hex_digit = '0;
        if (is_dig)
        begin
            hex_digit = c[3:0];
        end
        else if (((c >= CHAR_LC_A) && (c <= CHAR_LC_F)) ||
                 ((c >= CHAR_UC_A) && (c <= CHAR_UC_F)))
        begin
            // low nibble of a-f and A-F is 1..6
            hex_digit = c[3:0] + 4'd9;
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // decimal step: acc * 10 + digit, overflow if either step leaves 64 bits
    // ------------------------------------------------------------------------
    assign times_ten = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0};
    assign dec_sum   = {1'b0, times_ten} + {61'd0, c[3:0]};
    assign dec_ovf   = (acc_reg > DEC_LIMIT) || dec_sum[64];

    // ------------------------------------------------------------------------
    // suffix check and narrowing of a finished integer
    // ------------------------------------------------------------------------
    always_comb
    begin
        fin_kind  = KIND_ERROR;
        fin_value = '0;
        fin_fault = FAULT_BAD_SUFFIX;
        if (sfn_reg == 2'd0)
        begin
            fin_kind  = KIND_INT64;
            fin_value = acc_reg;
            fin_fault = FAULT_NONE;
        end
        else if (sfn_reg == 2'd1)
        begin
            if ((sfc_reg == CHAR_LC_S) || (sfc_reg == CHAR_UC_S))
            begin
                if (acc_reg[63:16] != '0)
                begin
                    fin_fault = FAULT_TOO_LARGE;
                end
                else
                begin
                    fin_kind  = KIND_INT16;
                    fin_value = acc_reg;
                    fin_fault = FAULT_NONE;
                end
            end
            else if ((sfc_reg == CHAR_LC_T) || (sfc_reg == CHAR_UC_T))
            begin
                if (acc_reg[63:32] != '0)
                begin
                    fin_fault = FAULT_TOO_LARGE;
                end
                else
                begin
                    fin_kind  = KIND_INT32;
                    fin_value = acc_reg;
                    fin_fault = FAULT_NONE;
                end
            end
            else if ((sfc_reg == CHAR_LC_X) || (sfc_reg == CHAR_UC_X))
            begin
                if (acc_reg[63:8] != '0)
                begin
                    fin_fault = FAULT_TOO_LARGE;
                end
                else
                begin
                    fin_kind  = KIND_BYTE;
                    fin_value = acc_reg;
                    fin_fault = FAULT_NONE;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // next scan state and result of the current byte
    // ------------------------------------------------------------------------
    always_comb
    begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        pf_next    = pf_reg;
        sfc_next   = sfc_reg;
        sfn_next   = sfn_reg;
        len_next   = len_reg;
        emit       = 1'b0;
        emit_kind  = KIND_INT64;
        emit_value = '0;
        emit_fault = FAULT_NONE;
        clear      = 1'b0;
        bump       = 1'b0;

        case (mode_reg)
            MODE_IDLE:
            begin
                if (!at_end && (c >= CHAR_1) && (c <= CHAR_9))
                begin
                    mode_next = MODE_DEC;
                    acc_next  = {60'd0, c[3:0]};
                    len_next  = 8'd1;
                end
                else if (!at_end && (c == CHAR_0))
                begin
                    mode_next = MODE_ZERO;
                    acc_next  = '0;
                    len_next  = 8'd1;
                end
            end

            MODE_ZERO, MODE_OCT, MODE_DEC:
            begin
                if ((mode_reg == MODE_ZERO) && !at_end && is_x)
                begin
                    mode_next = MODE_HEXX;
                    bump      = 1'b1;
                end
                else
                begin
                    // a leading zero not followed by x carries on as octal
                    if (mode_reg == MODE_ZERO)
                    begin
                        mode_next = MODE_OCT;
                    end
                    if (at_end)
                    begin
                        emit       = 1'b1;
                        emit_kind  = fin_kind;
                        emit_value = fin_value;
                        emit_fault = fin_fault;
                    end
                    else if ((mode_reg != MODE_DEC) && is_oct)
                    begin
                        bump = 1'b1;
                        if (acc_reg > OCT_LIMIT)
                        begin
                            mode_next = MODE_SKIPD;
                            pf_next   = FAULT_OCTAL;
                            acc_next  = '0;
                        end
                        else
                        begin
                            acc_next = {acc_reg[60:0], c[2:0]};
                        end
                    end
                    else if ((mode_reg != MODE_DEC) && is_dig)
                    begin
                        // 8 or 9 in an octal literal
                        bump      = 1'b1;
                        mode_next = MODE_SKIPD;
                        pf_next   = FAULT_OCTAL;
                        acc_next  = '0;
                    end
                    else if (is_dig)
                    begin
                        bump = 1'b1;
                        if (dec_ovf)
                        begin
                            mode_next = MODE_SKIPD;
                            pf_next   = FAULT_DECIMAL;
                            acc_next  = '0;
                        end
                        else
                        begin
                            acc_next = dec_sum[63:0];
                        end
                    end
                    else if (is_sep)
                    begin
                        bump = 1'b1;
                    end
                    else if (c == CHAR_DOT)
                    begin
                        mode_next = MODE_DOT;
                        pf_next   = FAULT_NONE;
                    end
                    else if (is_alnum)
                    begin
                        mode_next = MODE_SUF;
                        sfc_next  = c;
                        sfn_next  = 2'd1;
                        bump      = 1'b1;
                    end
                    else
                    begin
                        emit = 1'b1;
                        if (is_garb)
                        begin
                            emit_kind  = KIND_ERROR;
                            emit_fault = FAULT_GARBAGE;
                        end
                        else
                        begin
                            emit_kind  = fin_kind;
                            emit_value = fin_value;
                            emit_fault = fin_fault;
                        end
                    end
                end
            end

            MODE_HEXX:
            begin
                if (!at_end && is_hex)
                begin
                    mode_next = MODE_HEX;
                    acc_next  = {60'd0, hex_digit};
                    bump      = 1'b1;
                end
                else if (!at_end && is_garb)
                begin
                    emit       = 1'b1;
                    emit_kind  = KIND_ERROR;
                    emit_fault = FAULT_GARBAGE;
                end
                else
                begin
                    // bare 0x reads as a byte of value zero
                    emit      = 1'b1;
                    emit_kind = KIND_BYTE;
                end
            end

            MODE_HEX:
            begin
                if (at_end)
                begin
                    emit       = 1'b1;
                    emit_kind  = fin_kind;
                    emit_value = fin_value;
                    emit_fault = fin_fault;
                end
                else if (is_hex)
                begin
                    bump = 1'b1;
                    if (acc_reg > HEX_LIMIT)
                    begin
                        mode_next = MODE_SKIPH;
                        pf_next   = FAULT_HEX;
                        acc_next  = '0;
                    end
                    else
                    begin
                        acc_next = {acc_reg[59:0], hex_digit};
                    end
                end
                else if (is_sep)
                begin
                    bump = 1'b1;
                end
                else if (is_alnum)
                begin
                    mode_next = MODE_SUF;
                    sfc_next  = c;
                    sfn_next  = 2'd1;
                    bump      = 1'b1;
                end
                else
                begin
                    emit = 1'b1;
                    if (is_garb)
                    begin
                        emit_kind  = KIND_ERROR;
                        emit_fault = FAULT_GARBAGE;
                    end
                    else
                    begin
                        emit_kind  = fin_kind;
                        emit_value = fin_value;
                        emit_fault = fin_fault;
                    end
                end
            end

            MODE_SKIPD:
            begin
                if (!at_end && (is_dig || is_sep))
                begin
                    bump = 1'b1;
                end
                else if (!at_end && (c == CHAR_DOT))
                begin
                    mode_next = MODE_DOT;
                end
                else
                begin
                    emit       = 1'b1;
                    emit_kind  = KIND_ERROR;
                    emit_fault = pf_reg;
                end
            end

            MODE_SKIPH:
            begin
                if (!at_end && (is_hex || is_sep))
                begin
                    bump = 1'b1;
                end
                else
                begin
                    emit       = 1'b1;
                    emit_kind  = KIND_ERROR;
                    emit_fault = FAULT_HEX;
                end
            end

            MODE_DOT:
            begin
                emit = 1'b1;
                if (!at_end && (c == CHAR_DOT))
                begin
                    // range operator: the first dot ends the literal
                    if (pf_reg != FAULT_NONE)
                    begin
                        emit_kind  = KIND_ERROR;
                        emit_fault = pf_reg;
                    end
                    else
                    begin
                        emit_kind  = fin_kind;
                        emit_value = fin_value;
                        emit_fault = fin_fault;
                    end
                end
                else
                begin
                    emit_kind = KIND_REAL;
                end
            end

            MODE_SUF:
            begin
                if (at_end)
                begin
                    emit       = 1'b1;
                    emit_kind  = fin_kind;
                    emit_value = fin_value;
                    emit_fault = fin_fault;
                end
                else if (is_alnum)
                begin
                    bump = 1'b1;
                    if (sfn_reg < 2'd2)
                    begin
                        sfn_next = sfn_reg + 2'd1;
                    end
                end
                else
                begin
                    emit = 1'b1;
                    if (is_garb)
                    begin
                        emit_kind  = KIND_ERROR;
                        emit_fault = FAULT_GARBAGE;
                    end
                    else
                    begin
                        emit_kind  = fin_kind;
                        emit_value = fin_value;
                        emit_fault = fin_fault;
                    end
                end
            end

            default:
            begin
                clear = 1'b1;
            end
        endcase

        // saturating token length
        if (bump && (len_reg < LEN_CAP))
        begin
            len_next = len_reg + 8'd1;
        end

        // a finished literal returns the scanner to idle
        if (emit || clear)
        begin
            mode_next = MODE_IDLE;
            acc_next  = '0;
            pf_next   = FAULT_NONE;
            sfc_next  = '0;
            sfn_next  = '0;
            len_next  = '0;
        end
    end

    // ------------------------------------------------------------------------
    // scan state registers, updated only on an accepted byte beat
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
            pf_reg   <= FAULT_NONE;
            sfc_reg  <= '0;
            sfn_reg  <= '0;
            len_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            pf_reg   <= pf_next;
            sfc_reg  <= sfc_next;
            sfn_reg  <= sfn_next;
            len_reg  <= len_next;
        end
    end

    // ------------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------------
    always_comb
    begin
        if (accept)
        begin
            out_valid_next = emit;
        end
        else
        begin
            out_valid_next = out_valid_reg && !result_chan.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            kind_reg  <= emit_kind;
            value_reg <= emit_value;
            fault_reg <= emit_fault;
            tlen_reg  <= len_reg;
        end
    end

    assign result_chan.valid        = out_valid_reg;
    assign result_chan.kind         = kind_reg;
    assign result_chan.number_value = value_reg;
    assign result_chan.fault        = fault_reg;
    assign result_chan.token_length = tlen_reg;

endmodule

@@ design/ilsc_checker.sv @@
// ----------------------------------------------------------------------------
// ilsc_checker
// port-level checks of the integer literal scanner
// ----------------------------------------------------------------------------
module ilsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  kind,
    input logic [63:0] number_value,
    input logic [2:0]  fault
);
    import ilsc_pkg::*;

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(kind) &&
                                       $stable(number_value) && $stable(fault)))
        else $error("result beat changed while stalled");

    // a fresh result beat follows an accepted byte beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(out_valid && !out_ready)) |-> $past(in_valid && in_ready))
        else $error("result beat without a byte beat");

    // an empty output register never blocks the byte channel
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("byte channel stalled with output register empty");

    // errors carry a fault and no value, other kinds carry no fault
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((kind == KIND_ERROR) ?
                       (number_value == '0 && fault != FAULT_NONE) :
                       (fault == FAULT_NONE)))
        else $error("fault code inconsistent with result kind");

    // narrowed kinds stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_INT16 || kind == KIND_INT32 || kind == KIND_BYTE ||
                       kind == KIND_REAL)) |->
        ((kind == KIND_INT16) ? (number_value[63:16] == '0) :
         (kind == KIND_INT32) ? (number_value[63:32] == '0) :
         (kind == KIND_BYTE)  ? (number_value[63:8] == '0)  :
                                (number_value == '0)))
        else $error("narrowed value out of range");

endmodule

bind integer_literal_scanner_top ilsc_checker u_ilsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (byte_chan.valid),
    .in_ready     (byte_chan.ready),
    .out_valid    (result_chan.valid),
    .out_ready    (result_chan.ready),
    .kind         (result_chan.kind),
    .number_value (result_chan.number_value),
    .fault        (result_chan.fault)
);
